@@ rtl/tpcr_pkg.sv @@
// Shared types and constants for the touch point calibrate/rotate block.
// No dependencies; imported by every module under rtl/.
package tpcr_pkg;

    localparam int C_RAW_W    = 16;                   // raw and screen coordinate width
    localparam int C_SIZE_W   = 12;                   // holds screen size minus one (max 4095)
    localparam int C_NUM_W    = C_RAW_W + C_SIZE_W;   // scaled numerator width
    localparam int C_CNT_W    = $clog2(C_NUM_W + 1);  // divider step counter
    localparam int C_STAT_W   = 8;
    localparam int C_READY_BIT = 7;
    localparam int C_COUNT_W  = 4;                    // touch count field, bits 3..0
    localparam int C_ORIENT_W = 2;
    localparam int C_IDX_W    = 3;
    localparam int C_Q_DEPTH  = 2;
    localparam int C_QP_W     = $clog2(C_Q_DEPTH);
    localparam int C_QC_W     = $clog2(C_Q_DEPTH + 1);

    typedef enum logic [C_IDX_W-1:0] {
        CFG_CAL_ENABLE  = 3'd0,
        CFG_CAL_X_LOW   = 3'd1,
        CFG_CAL_X_HIGH  = 3'd2,
        CFG_CAL_Y_LOW   = 3'd3,
        CFG_CAL_Y_HIGH  = 3'd4,
        CFG_ORIENTATION = 3'd5
    } t_cfg_idx;

    typedef enum logic [C_ORIENT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef struct packed {
        logic               cal_enable;
        logic [C_RAW_W-1:0] x_low;
        logic [C_RAW_W-1:0] x_high;
        logic [C_RAW_W-1:0] y_low;
        logic [C_RAW_W-1:0] y_high;
        t_rot               orientation;
    } t_cfg;

    // held state after one poll, handed from front to back
    typedef struct packed {
        logic               touched;
        logic [C_RAW_W-1:0] x;
        logic [C_RAW_W-1:0] y;
    } t_job;

endpackage

@@ rtl/tpcr_front.sv @@
// Front end: takes controller polls, keeps the held touch state, queues jobs.
// Depends on tpcr_pkg.
module tpcr_front import tpcr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [C_STAT_W-1:0] i_point_status,
    input  logic [C_RAW_W-1:0]  i_raw_x,
    input  logic [C_RAW_W-1:0]  i_raw_y,
    input  logic                i_q_full,
    output logic                o_q_push,
    output t_job                o_q_job
);

    logic               r_touch, n_touch;
    logic [C_RAW_W-1:0] r_hx, n_hx;
    logic [C_RAW_W-1:0] r_hy, n_hy;

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        n_touch = r_touch;
        n_hx    = r_hx;
        n_hy    = r_hy;
        if (i_point_status[C_READY_BIT]) begin
            n_touch = |i_point_status[C_COUNT_W-1:0];
            if (n_touch) begin
                n_hx = i_raw_x;
                n_hy = i_raw_y;
            end
        end
    end

    assign o_q_job = '{touched: n_touch, x: n_hx, y: n_hy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch <= 1'b0;
            r_hx    <= '0;
            r_hy    <= '0;
        end else if (o_q_push) begin
            r_touch <= n_touch;
            r_hx    <= n_hx;
            r_hy    <= n_hy;
        end
    end

endmodule

@@ rtl/tpcr_queue.sv @@
// Two-entry job queue between front and back ends.
// Depends on tpcr_pkg.
module tpcr_queue import tpcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [C_Q_DEPTH];
    logic [C_QP_W-1:0] r_wp;
    logic [C_QP_W-1:0] r_rp;
    logic [C_QC_W-1:0] r_cnt;

    assign o_full  = (r_cnt == C_QC_W'(C_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/tpcr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on tpcr_pkg. Quotient is known to fit in C_RAW_W bits.
module tpcr_div import tpcr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [C_NUM_W-1:0] i_num,
    input  logic [C_RAW_W-1:0] i_den,
    output logic               o_done,
    output logic [C_RAW_W-1:0] o_quot
);

    logic [C_NUM_W-1:0] r_num;
    logic [C_RAW_W-1:0] r_rem;
    logic [C_RAW_W-1:0] r_den;
    logic [C_CNT_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [C_RAW_W:0]   trial;
    logic [C_RAW_W:0]   diff;
    logic               ge;

    assign trial  = {r_rem, r_num[C_NUM_W-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign diff   = trial - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_num[C_RAW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[C_RAW_W-1:0] : trial[C_RAW_W-1:0];
            r_num <= {r_num[C_NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_CNT_W'(C_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == C_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/tpcr_back.sv @@
// Back end: clamp, scale by iterative division, rotate, output register.
// Depends on tpcr_pkg and tpcr_div.
module tpcr_back import tpcr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_job               i_q_job,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_touched,
    output logic [C_RAW_W-1:0] o_screen_x,
    output logic [C_RAW_W-1:0] o_screen_y
);

    localparam logic [C_SIZE_W-1:0] W1_S = C_SIZE_W'(SCREEN_WIDTH - 1);
    localparam logic [C_SIZE_W-1:0] H1_S = C_SIZE_W'(SCREEN_HEIGHT - 1);
    localparam logic [C_RAW_W-1:0]  W1   = C_RAW_W'(SCREEN_WIDTH - 1);
    localparam logic [C_RAW_W-1:0]  H1   = C_RAW_W'(SCREEN_HEIGHT - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLAMP = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state             r_state;
    logic               r_touch;
    logic [C_RAW_W-1:0] r_x, r_y;
    logic [C_RAW_W-1:0] r_dx, r_dy;
    logic [C_NUM_W-1:0] r_px, r_py;
    logic               r_div_start;
    logic               r_out_valid;
    logic               r_out_touch;
    logic [C_RAW_W-1:0] r_out_x, r_out_y;

    logic               cal_act;
    logic [C_RAW_W-1:0] cx, cy;
    logic               x_done, y_done;
    logic [C_RAW_W-1:0] x_quot, y_quot;
    logic [C_RAW_W-1:0] rot_x, rot_y;
    logic               out_load;

    assign cal_act = i_cfg.cal_enable && (i_cfg.x_high > i_cfg.x_low)
                     && (i_cfg.y_high > i_cfg.y_low);
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    // clamp into [low, high]
    always_comb begin
        cx = r_x;
        if (r_x < i_cfg.x_low)  cx = i_cfg.x_low;
        if (r_x > i_cfg.x_high) cx = i_cfg.x_high;
        cy = r_y;
        if (r_y < i_cfg.y_low)  cy = i_cfg.y_low;
        if (r_y > i_cfg.y_high) cy = i_cfg.y_high;
    end

    tpcr_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_px),
        .i_den   (i_cfg.x_high - i_cfg.x_low),
        .o_done  (x_done),
        .o_quot  (x_quot)
    );

    tpcr_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_py),
        .i_den   (i_cfg.y_high - i_cfg.y_low),
        .o_done  (y_done),
        .o_quot  (y_quot)
    );

    // quarter turns, 16-bit wrap; untouched results stay zero
    always_comb begin
        rot_x = r_x;
        rot_y = r_y;
        case (i_cfg.orientation)
            ROT_90: begin
                rot_x = r_y;
                rot_y = W1 - r_x;
            end
            ROT_180: begin
                rot_x = W1 - r_x;
                rot_y = H1 - r_y;
            end
            ROT_270: begin
                rot_x = H1 - r_y;
                rot_y = r_x;
            end
            default: begin
                rot_x = r_x;
                rot_y = r_y;
            end
        endcase
        if (!r_touch) begin
            rot_x = '0;
            rot_y = '0;
        end
    end

    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_touched   = r_out_touch;
    assign o_screen_x  = r_out_x;
    assign o_screen_y  = r_out_y;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_touch <= i_q_job.touched;
                r_x     <= i_q_job.x;
                r_y     <= i_q_job.y;
            end
            S_CLAMP: begin
                r_dx <= cx - i_cfg.x_low;
                r_dy <= cy - i_cfg.y_low;
            end
            S_MUL: begin
                r_px <= {{C_SIZE_W{1'b0}}, r_dx} * {{C_RAW_W{1'b0}}, W1_S};
                r_py <= {{C_SIZE_W{1'b0}}, r_dy} * {{C_RAW_W{1'b0}}, H1_S};
            end
            S_DIV: begin
                if (x_done && y_done) begin
                    r_x <= x_quot;
                    r_y <= y_quot;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_touch <= r_touch;
            r_out_x     <= rot_x;
            r_out_y     <= rot_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= (i_q_job.touched && cal_act) ? S_CLAMP : S_OUT;
                    end
                end
                S_CLAMP: r_state <= S_MUL;
                S_MUL: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (x_done && y_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/touch_point_calibrate_rotate.sv @@
// Touch point calibrate/rotate: top level, configuration registers, assertions.
// Depends on tpcr_pkg, tpcr_front, tpcr_queue, tpcr_back.
//
// One result word per input poll, in order. Polls enter a two-entry queue at one per cycle
// while it has room; the back end then sends a poll that needs no scaling (not touched, or
// calibration off or degenerate) straight to output, and a scaled one through clamp, multiply
// and the two 28-step restoring dividers that run in parallel for x and y. Results sit in
// an output register, so the back end works on while the queue keeps taking polls.
// Calibration and orientation registers must only be written while the block is idle.
module touch_point_calibrate_rotate import tpcr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [C_IDX_W-1:0]  i_cfg_index,
    input  logic [C_RAW_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [C_STAT_W-1:0] i_point_status,
    input  logic [C_RAW_W-1:0]  i_raw_x,
    input  logic [C_RAW_W-1:0]  i_raw_y,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_touched,
    output logic [C_RAW_W-1:0]  o_screen_x,
    output logic [C_RAW_W-1:0]  o_screen_y
);

    t_cfg r_cfg;
    logic q_push, q_pop, q_full, q_empty;
    t_job q_in_job, q_out_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{cal_enable: 1'b0, x_low: '0, x_high: '0, y_low: '0, y_high: '0,
                       orientation: ROT_0};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CAL_ENABLE:  r_cfg.cal_enable  <= i_cfg_data[0];
                CFG_CAL_X_LOW:   r_cfg.x_low       <= i_cfg_data;
                CFG_CAL_X_HIGH:  r_cfg.x_high      <= i_cfg_data;
                CFG_CAL_Y_LOW:   r_cfg.y_low       <= i_cfg_data;
                CFG_CAL_Y_HIGH:  r_cfg.y_high      <= i_cfg_data;
                CFG_ORIENTATION: r_cfg.orientation <= t_rot'(i_cfg_data[C_ORIENT_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    tpcr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_status (i_point_status),
        .i_raw_x        (i_raw_x),
        .i_raw_y        (i_raw_y),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_job        (q_in_job)
    );

    tpcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tpcr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_job     (q_out_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_touched   (o_touched),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_touched) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("untouched result carries nonzero coordinates");

    a_empty_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_empty && !q_push) |=> !q_full)
        else $error("queue went from empty to full in one cycle");

endmodule

@@ tb/tpcr_checker.sv @@
// Scoreboard for touch_point_calibrate_rotate: tracks register writes and held touch
// state, predicts one result word per accepted poll and compares in order.
// Depends on tpcr_pkg.
module tpcr_checker import tpcr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [C_IDX_W-1:0]  i_cfg_index,
    input  logic [C_RAW_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [C_STAT_W-1:0] i_point_status,
    input  logic [C_RAW_W-1:0]  i_raw_x,
    input  logic [C_RAW_W-1:0]  i_raw_y,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_touched,
    input  logic [C_RAW_W-1:0]  i_screen_x,
    input  logic [C_RAW_W-1:0]  i_screen_y,
    output int                  o_fail_count,
    output int                  o_words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg cal_regs;
    t_job held;
    t_job owed_q[$];

    initial begin
        o_fail_count = 0;
        o_words_owed = 0;
    end

    // clamp to [lo,hi], then map onto 0..size-1 with truncating division
    function automatic logic [C_RAW_W-1:0] scale_axis(logic [C_RAW_W-1:0] v,
                                                      logic [C_RAW_W-1:0] lo,
                                                      logic [C_RAW_W-1:0] hi,
                                                      int size);
        logic [C_RAW_W-1:0] c;
        longint unsigned    num;
        c = (v < lo) ? lo : ((v > hi) ? hi : v);
        num = 64'(c - lo) * 64'(size - 1);
        return C_RAW_W'(num / 64'(hi - lo));
    endfunction

    function automatic t_job screen_point(t_job h, t_cfg c);
        t_job               r;
        logic [C_RAW_W-1:0] x;
        logic [C_RAW_W-1:0] y;
        r = '0;
        if (h.touched) begin
            x = h.x;
            y = h.y;
            if (c.cal_enable && c.x_high > c.x_low && c.y_high > c.y_low) begin
                x = scale_axis(x, c.x_low, c.x_high, SCREEN_WIDTH);
                y = scale_axis(y, c.y_low, c.y_high, SCREEN_HEIGHT);
            end
            r.touched = 1'b1;
            // 16-bit subtraction wraps when the raw value exceeds the screen
            case (c.orientation)
                ROT_90: begin
                    r.x = y;
                    r.y = C_RAW_W'(SCREEN_WIDTH - 1) - x;
                end
                ROT_180: begin
                    r.x = C_RAW_W'(SCREEN_WIDTH - 1) - x;
                    r.y = C_RAW_W'(SCREEN_HEIGHT - 1) - y;
                end
                ROT_270: begin
                    r.x = C_RAW_W'(SCREEN_HEIGHT - 1) - y;
                    r.y = x;
                end
                default: begin
                    r.x = x;
                    r.y = y;
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, logic [C_RAW_W-1:0] got);
        if (got !== C_RAW_W'(want)) begin
            o_fail_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_job want;
        if (!i_rst_n) begin
            cal_regs = '0;
            held = '0;
            owed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CAL_ENABLE:  cal_regs.cal_enable = i_cfg_data[0];
                    CFG_CAL_X_LOW:   cal_regs.x_low = i_cfg_data;
                    CFG_CAL_X_HIGH:  cal_regs.x_high = i_cfg_data;
                    CFG_CAL_Y_LOW:   cal_regs.y_low = i_cfg_data;
                    CFG_CAL_Y_HIGH:  cal_regs.y_high = i_cfg_data;
                    CFG_ORIENTATION: cal_regs.orientation = t_rot'(i_cfg_data[C_ORIENT_W-1:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: unexpected word expected none actual %0d/%0d/%0d",
                             $time, i_touched, i_screen_x, i_screen_y);
                end else begin
                    want = owed_q.pop_front();
                    check_field("touched", want.touched, C_RAW_W'(i_touched));
                    check_field("screen_x", want.x, i_screen_x);
                    check_field("screen_y", want.y, i_screen_y);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                // ready bit clear: held state stays as it is
                if (i_point_status[C_READY_BIT]) begin
                    held.touched = |i_point_status[C_COUNT_W-1:0];
                    if (held.touched) begin
                        held.x = i_raw_x;
                        held.y = i_raw_y;
                    end
                end
                owed_q.push_back(screen_point(held, cal_regs));
            end
        end
        o_words_owed = owed_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the touch_point_calibrate_rotate testbench: clock, reset, stimulus and verdict.
// Depends on tpcr_pkg, the block under test and tpcr_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tpcr_pkg::*;

    localparam int SCREEN_W        = 480;
    localparam int SCREEN_H        = 320;
    localparam int HALF_PERIOD     = 6;
    localparam int PHASES          = 12;
    localparam int POLLS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 800000;

    // indexes past the register map; writes there must be dropped
    localparam logic [C_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [C_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [C_IDX_W-1:0]  i_cfg_index = '0;
    logic [C_RAW_W-1:0]  i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [C_STAT_W-1:0] i_point_status = '0;
    logic [C_RAW_W-1:0]  i_raw_x = '0;
    logic [C_RAW_W-1:0]  i_raw_y = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_touched;
    logic [C_RAW_W-1:0]  o_screen_x;
    logic [C_RAW_W-1:0]  o_screen_y;

    int fail_count;
    int words_owed;
    int send_idle_pct = 20;
    int recv_stall_pct = 73;
    int cycles = 0;

    logic [C_RAW_W-1:0] cur_xl = '0;
    logic [C_RAW_W-1:0] cur_xh = '0;
    logic [C_RAW_W-1:0] cur_yl = '0;
    logic [C_RAW_W-1:0] cur_yh = '0;

    touch_point_calibrate_rotate #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_status (i_point_status),
        .i_raw_x        (i_raw_x),
        .i_raw_y        (i_raw_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_touched      (o_touched),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y)
    );

    tpcr_checker #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_point_status (i_point_status),
        .i_raw_x        (i_raw_x),
        .i_raw_y        (i_raw_y),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_touched      (o_touched),
        .i_screen_x     (o_screen_x),
        .i_screen_y     (o_screen_y),
        .o_fail_count   (fail_count),
        .o_words_owed   (words_owed)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_poll(input logic [C_STAT_W-1:0] status,
                             input logic [C_RAW_W-1:0] x, input logic [C_RAW_W-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_status <= status;
        i_raw_x <= x;
        i_raw_y <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (words_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [C_IDX_W-1:0] idx, input logic [C_RAW_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // unused upper data bits carry noise; spare indexes get junk too
    task automatic program_regs(input logic en, input logic [C_RAW_W-1:0] xl,
                                input logic [C_RAW_W-1:0] xh, input logic [C_RAW_W-1:0] yl,
                                input logic [C_RAW_W-1:0] yh, input t_rot rot);
        write_reg(CFG_CAL_ENABLE, {15'($urandom), en});
        write_reg(CFG_CAL_X_LOW, xl);
        write_reg(CFG_CAL_X_HIGH, xh);
        write_reg(CFG_CAL_Y_LOW, yl);
        write_reg(CFG_CAL_Y_HIGH, yh);
        write_reg(CFG_ORIENTATION, {14'($urandom), rot});
        write_reg(CFG_SPARE_6, C_RAW_W'($urandom));
        write_reg(CFG_SPARE_7, C_RAW_W'($urandom));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        cur_xl = xl;
        cur_xh = xh;
        cur_yl = yl;
        cur_yh = yh;
    endtask

    task automatic program_profile(input int p);
        logic [C_RAW_W-1:0] a;
        logic [C_RAW_W-1:0] b;
        logic [C_RAW_W-1:0] c;
        logic [C_RAW_W-1:0] d;
        t_rot               rot;
        a = C_RAW_W'($urandom_range(0, 65534));
        b = C_RAW_W'($urandom_range(a + 1, 65535));
        c = C_RAW_W'($urandom_range(0, 65534));
        d = C_RAW_W'($urandom_range(c + 1, 65535));
        rot = t_rot'(p % 4);
        case (p % 7)
            0: program_regs(1'b0, C_RAW_W'($urandom), C_RAW_W'($urandom),
                            C_RAW_W'($urandom), C_RAW_W'($urandom), rot);
            1: program_regs(1'b1, 16'd200, 16'd3800, 16'd300, 16'd3700, rot);
            2: program_regs(1'b1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, rot);
            3: program_regs(1'b1, 16'hFFFE, 16'hFFFF, 16'd0, 16'd1, rot);
            4: program_regs(1'b1, a, a, c, d, rot);     // degenerate x range
            5: program_regs(1'b1, a, b, d, c, rot);     // y range inverted
            default: program_regs(1'b1, a, b, c, d, rot);
        endcase
    endtask

    function automatic logic [C_RAW_W-1:0] pick_coord(logic [C_RAW_W-1:0] lo,
                                                      logic [C_RAW_W-1:0] hi);
        logic [C_RAW_W-1:0] a;
        logic [C_RAW_W-1:0] b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return lo;
            3: return hi;
            4, 5, 6: return C_RAW_W'($urandom_range(a, b));
            default: return C_RAW_W'($urandom);
        endcase
    endfunction

    task automatic send_random_poll();
        logic [C_STAT_W-1:0] status;
        int unsigned         kind;
        kind = $urandom_range(0, 99);
        if (kind < 60)
            status = {1'b1, 3'($urandom), 4'($urandom_range(1, 15))};
        else if (kind < 75)
            status = {1'b1, 3'($urandom), 4'd0};
        else
            status = {1'b0, 7'($urandom)};
        send_poll(status, pick_coord(cur_xl, cur_xh), pick_coord(cur_yl, cur_yh));
    endtask

    initial begin
        int p;
        int n;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: no calibration, no rotation
        send_poll(8'h0F, 16'd5, 16'd6);         // not ready, nothing held yet
        send_poll(8'h81, 16'd0, 16'd0);
        send_poll(8'h8F, 16'hFFFF, 16'hFFFF);
        send_poll(8'h7F, 16'd1, 16'd2);         // not ready, keeps held point
        send_poll(8'h80, 16'hAAAA, 16'h5555);   // release scan
        send_poll(8'h00, 16'd9, 16'd9);
        send_poll(8'hF1, 16'h1234, 16'h5678);   // bits 6..4 ignored
        send_poll(8'h70, 16'd0, 16'd0);

        wait_all_results();
        program_regs(1'b1, 16'd100, 16'd3900, 16'd200, 16'd3800, ROT_90);
        send_poll(8'h81, 16'd50, 16'd150);      // below both lows
        send_poll(8'h82, 16'd4000, 16'hFFFF);   // above both highs
        send_poll(8'h83, 16'd100, 16'd3800);
        send_poll(8'h84, 16'd3900, 16'd200);
        send_poll(8'h85, 16'd2000, 16'd2000);

        wait_all_results();
        program_regs(1'b1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, ROT_180);
        send_poll(8'h81, 16'hFFFF, 16'hFFFF);
        send_poll(8'h81, 16'd0, 16'd0);
        send_poll(8'h81, 16'h8000, 16'd1);

        // calibration off: raw values beyond the screen wrap on rotation
        wait_all_results();
        program_regs(1'b0, 16'd100, 16'd3900, 16'd200, 16'd3800, ROT_270);
        send_poll(8'h81, 16'd1000, 16'hFFFF);
        send_poll(8'h81, 16'd0, 16'd479);

        wait_all_results();
        program_regs(1'b1, 16'd500, 16'd500, 16'd200, 16'd3800, ROT_180);
        send_poll(8'h81, 16'd600, 16'd700);
        wait_all_results();
        program_regs(1'b1, 16'd100, 16'd3900, 16'd3800, 16'd200, ROT_0);
        send_poll(8'h81, 16'd600, 16'd700);
        send_poll(8'h80, 16'd0, 16'd0);
        send_poll(8'h00, 16'd0, 16'd0);

        for (p = 0; p < PHASES; p++) begin
            wait_all_results();
            if (p == 4) begin
                send_idle_pct = 73;
                recv_stall_pct = 20;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            program_profile(p);
            for (n = 0; n < POLLS_PER_PHASE; n++) begin
                if (p == 2 && n == POLLS_PER_PHASE / 2)
                    wait_all_results();
                send_random_poll();
            end
        end

        wait_all_results();
        if (fail_count == 0 && words_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
